/* design/ilt_pkg.sv */
package ilt_pkg;

	localparam int unsigned MAX_PARAMS = 15;

	localparam int unsigned TDATA_IN_W  = 8;
	localparam int unsigned TDATA_OUT_W = 32;

	typedef enum logic [2:0] {
		CLS_SEP   = 3'd0,
		CLS_TAG   = 3'd1,
		CLS_NICK  = 3'd2,
		CLS_HOST  = 3'd3,
		CLS_CMD   = 3'd4,
		CLS_PARAM = 3'd5,
		CLS_TRAIL = 3'd6,
		CLS_DROP  = 3'd7
	} byte_class_t;

	// tuser code of an input item
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] CMD_LEN_MAX = 3'd7;
	localparam logic [2:0] NUM_DIGITS  = 3'd3;

	// result tdata bit positions
	localparam int unsigned OD_IDX_LSB  = 0;
	localparam int unsigned OD_BYTE_LSB = 4;
	localparam int unsigned OD_OK       = 12;
	localparam int unsigned OD_NUMV     = 13;
	localparam int unsigned OD_NUM_LSB  = 14;
	localparam int unsigned OD_CNT_LSB  = 24;

endpackage

/* design/irc_line_tokenizer.sv */
// IRC line tokenizer.
// Slave stream: one line character per item in s_axis_tdata, s_axis_tuser high marks the
// end-of-line item (its tdata is ignored). Master stream: one result item per input item.
// m_axis_tuser gives the byte class, m_axis_tlast marks the end-of-line result, which
// carries line_ok, the numeric reply value and the kept parameter count; data results
// carry the byte and its parameter index.
// An accepted input passes one input register and one result register before its result
// shows on the master side. Throughput: one item per cycle unless the receiver stalls;
// the parse state, a small phase register, takes one byte classification per cycle.
// Reset clears both stage valids and returns the parser to the start of a line.
// When the receiver stalls the result register holds; the input register keeps taking
// an item until it is full, after which s_axis_tready falls in the same cycle.
module irc_line_tokenizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ilt_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  logic                               s_axis_tuser,  // [0] end_of_line
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [3:0] param_index, [11:4] byte_out, [12] line_ok, [13] numeric_valid,
	// [23:14] numeric_value, [27:24] param_count, [31:28] zero
	output logic [ilt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
	output logic [2:0]                         m_axis_tuser,  // [2:0] byte_class
	output logic                               m_axis_tlast   // line_done
);
	import ilt_pkg::*;

	typedef enum logic [3:0] {
		PH_START, PH_TAGS, PH_AFTER_TAGS, PH_NICK, PH_HOST, PH_AFTER_PREFIX,
		PH_CMD, PH_GAP, PH_PARAM, PH_DROP, PH_TRAIL
	} phase_t;

	// input stage
	logic       valid_s1;
	logic       eol_s1;
	logic [7:0] byte_s1;

	// parse state
	phase_t     phase_q;
	logic [3:0] kept_q;
	logic [9:0] accum_q;
	logic [2:0] cmd_len_q;
	logic       all_dig_q;
	logic       host_seen_q;

	// result stage
	logic                   valid_s2;
	logic [TDATA_OUT_W-1:0] data_s2;
	byte_class_t            cls_s2;
	logic                   last_s2;

	logic advance;
	logic take_in;

	phase_t      phase_d;
	logic [3:0]  kept_d;
	logic [9:0]  accum_d;
	logic [2:0]  cmd_len_d;
	logic        all_dig_d;
	logic        host_seen_d;
	byte_class_t cls_d;
	logic [3:0]  idx_d;
	logic        take_cmd;
	logic        is_dig;
	logic        line_ok;
	logic        num_ok;
	logic [9:0]  num_val;
	logic [TDATA_OUT_W-1:0] data_d;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = cls_s2;
	assign m_axis_tlast  = last_s2;

	assign is_dig = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);

	always_comb begin
		phase_d     = phase_q;
		kept_d      = kept_q;
		host_seen_d = host_seen_q;
		cls_d       = CLS_SEP;
		idx_d       = 4'd0;
		take_cmd    = 1'b0;

		case (phase_q)
			PH_TAGS: begin
				if (byte_s1 == CH_SPACE) phase_d = PH_AFTER_TAGS;
				else cls_d = CLS_TAG;
			end
			PH_AFTER_TAGS: begin
				if (byte_s1 == CH_COLON) phase_d = PH_NICK;
				else if (byte_s1 != CH_SPACE) take_cmd = 1'b1;
			end
			PH_NICK: begin
				if (byte_s1 == CH_SPACE) phase_d = PH_AFTER_PREFIX;
				else if (byte_s1 == CH_BANG) begin
					host_seen_d = 1'b1;
					phase_d     = PH_HOST;
				end else cls_d = CLS_NICK;
			end
			PH_HOST: begin
				if (byte_s1 == CH_SPACE) phase_d = PH_AFTER_PREFIX;
				else cls_d = CLS_HOST;
			end
			PH_AFTER_PREFIX: begin
				if (byte_s1 != CH_SPACE) take_cmd = 1'b1;
			end
			PH_CMD: begin
				if (byte_s1 == CH_SPACE) phase_d = PH_GAP;
				else take_cmd = 1'b1;
			end
			PH_GAP: begin
				if (byte_s1 == CH_COLON) phase_d = PH_TRAIL;
				else if (byte_s1 != CH_SPACE) begin
					if (kept_q < 4'(MAX_PARAMS)) begin
						idx_d   = kept_q;
						kept_d  = kept_q + 4'd1;
						phase_d = PH_PARAM;
						cls_d   = CLS_PARAM;
					end else begin
						phase_d = PH_DROP;
						cls_d   = CLS_DROP;
					end
				end
			end
			PH_PARAM: begin
				if (byte_s1 == CH_SPACE) phase_d = PH_GAP;
				else begin
					cls_d = CLS_PARAM;
					idx_d = kept_q - 4'd1;
				end
			end
			PH_DROP: begin
				if (byte_s1 == CH_SPACE) phase_d = PH_GAP;
				else cls_d = CLS_DROP;
			end
			PH_TRAIL: cls_d = CLS_TRAIL;
			default: begin
				if (byte_s1 == CH_AT) phase_d = PH_TAGS;
				else if (byte_s1 == CH_COLON) phase_d = PH_NICK;
				else if (byte_s1 == CH_SPACE) phase_d = PH_GAP;
				else take_cmd = 1'b1;
			end
		endcase

		accum_d   = accum_q;
		cmd_len_d = cmd_len_q;
		all_dig_d = all_dig_q;
		if (take_cmd) begin
			cls_d     = CLS_CMD;
			phase_d   = PH_CMD;
			all_dig_d = all_dig_q && is_dig;
			// accum * 10 + digit, kept to 10 bits
			if (is_dig && cmd_len_q < NUM_DIGITS)
				accum_d = {accum_q[6:0], 3'b000} + {accum_q[8:0], 1'b0}
					+ {6'd0, byte_s1[3:0]};
			if (cmd_len_q < CMD_LEN_MAX) cmd_len_d = cmd_len_q + 3'd1;
		end
	end

	assign line_ok = (phase_q == PH_CMD) || (phase_q == PH_GAP) || (phase_q == PH_PARAM)
		|| (phase_q == PH_DROP) || (phase_q == PH_TRAIL);
	assign num_ok  = line_ok && (cmd_len_q == NUM_DIGITS) && all_dig_q;
	assign num_val = num_ok ? accum_q : 10'd0;

	always_comb begin
		data_d = '0;
		if (eol_s1) begin
			data_d[OD_OK]                = line_ok;
			data_d[OD_NUMV]              = num_ok;
			data_d[OD_NUM_LSB +: 10]     = num_val;
			data_d[OD_CNT_LSB +: 4]      = kept_q;
		end else begin
			data_d[OD_IDX_LSB +: 4]      = idx_d;
			data_d[OD_BYTE_LSB +: 8]     = byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			eol_s1  <= (s_axis_tuser == KIND_EOL);
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			kept_q      <= 4'd0;
			accum_q     <= 10'd0;
			cmd_len_q   <= 3'd0;
			all_dig_q   <= 1'b1;
			host_seen_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (eol_s1) begin
				// back to the start of a line
				phase_q     <= PH_START;
				kept_q      <= 4'd0;
				accum_q     <= 10'd0;
				cmd_len_q   <= 3'd0;
				all_dig_q   <= 1'b1;
				host_seen_q <= 1'b0;
			end else begin
				phase_q     <= phase_d;
				kept_q      <= kept_d;
				accum_q     <= accum_d;
				cmd_len_q   <= cmd_len_d;
				all_dig_q   <= all_dig_d;
				host_seen_q <= host_seen_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			data_s2 <= data_d;
			cls_s2  <= eol_s1 ? CLS_SEP : cls_d;
			last_s2 <= eol_s1;
		end
	end

endmodule

/* design/ilt_checker.sv */
module ilt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [ilt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
	input logic [2:0]                         m_axis_tuser,
	input logic                               m_axis_tlast
);
	import ilt_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// end-of-line item carries no byte and is a separator
	a_eol_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == CLS_SEP
			&& m_axis_tdata[OD_BYTE_LSB +: 8] == 8'd0 && m_axis_tdata[3:0] == 4'd0)
		else $error("malformed end-of-line result");

	// line summary only on end of line
	a_data_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:OD_OK] == '0)
		else $error("line summary on a data result");

	a_numeric: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OD_NUMV] |-> m_axis_tdata[OD_OK]
			&& m_axis_tdata[OD_NUM_LSB +: 10] <= 10'd999)
		else $error("numeric reply on an invalid line");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] != 4'd0 |-> m_axis_tuser == CLS_PARAM)
		else $error("parameter index outside a parameter");

endmodule

bind irc_line_tokenizer ilt_checker u_ilt_checker (.*);

/* sim/tb_top.sv */
module tb_top;
	import ilt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_AT_ITEM = 300;
	localparam int HOLD_CYCLES  = 120;
	localparam int CALM_FROM    = 500;
	localparam int CALM_TO      = 700;

	typedef enum logic [3:0] {
		PH_START,
		PH_TAGS,
		PH_AFTER_TAGS,
		PH_NICK,
		PH_HOST,
		PH_AFTER_PREFIX,
		PH_CMD,
		PH_GAP,
		PH_PARAM,
		PH_DROP,
		PH_TRAIL
	} line_phase_t;

	typedef struct packed {
		byte_class_t cls;
		logic [3:0]  idx;
		logic [7:0]  byte_out;
		logic        done;
		logic        ok;
		logic        numv;
		logic [9:0]  num;
		logic [3:0]  cnt;
	} tok_result_t;

	typedef struct {
		logic        kind;
		logic [7:0]  data;
		bit          typed;
		tok_result_t want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = KIND_DATA;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic [2:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	stim_row_t   stim[$];
	tok_result_t expected_tokens[$];
	int          send_idx = 0;
	int          cycle_count = 0;
	int          errors = 0;
	logic        rx_hold = 1'b0;

	// line parser state
	line_phase_t ln_phase = PH_START;
	logic [3:0]  ln_params = '0;
	logic [9:0]  num_acc = '0;
	logic [2:0]  cmd_len = '0;
	logic        cmd_digits = 1'b1;

	irc_line_tokenizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void start_line();
		ln_phase   = PH_START;
		ln_params  = '0;
		num_acc    = '0;
		cmd_len    = '0;
		cmd_digits = 1'b1;
	endfunction

	function automatic void absorb_cmd_char(logic [7:0] b);
		logic dig;
		dig = (b >= CH_ZERO && b <= CH_NINE);
		if (!dig)
			cmd_digits = 1'b0;
		if (dig && cmd_len < NUM_DIGITS)
			num_acc = 10'(num_acc * 10 + (b - CH_ZERO));
		if (cmd_len < CMD_LEN_MAX)
			cmd_len++;
		ln_phase = PH_CMD;
	endfunction

	function automatic tok_result_t tokenize_item(logic kind, logic [7:0] b);
		tok_result_t r;
		logic ok;
		r = '0;
		if (kind == KIND_EOL) begin
			ok = (ln_phase >= PH_CMD && ln_phase <= PH_TRAIL);
			r.done = 1'b1;
			r.ok   = ok;
			r.numv = ok && cmd_len == NUM_DIGITS && cmd_digits;
			r.num  = r.numv ? num_acc : '0;
			r.cnt  = ln_params;
			start_line();
			return r;
		end
		r.byte_out = b;
		r.cls = CLS_SEP;
		case (ln_phase)
			PH_TAGS: begin
				if (b == CH_SPACE) ln_phase = PH_AFTER_TAGS;
				else r.cls = CLS_TAG;
			end
			PH_AFTER_TAGS: begin
				if (b == CH_COLON) begin
					ln_phase = PH_NICK;
				end else if (b != CH_SPACE) begin
					absorb_cmd_char(b);
					r.cls = CLS_CMD;
				end
			end
			PH_NICK: begin
				if (b == CH_SPACE) ln_phase = PH_AFTER_PREFIX;
				else if (b == CH_BANG) ln_phase = PH_HOST;
				else r.cls = CLS_NICK;
			end
			PH_HOST: begin
				if (b == CH_SPACE) ln_phase = PH_AFTER_PREFIX;
				else r.cls = CLS_HOST;
			end
			PH_AFTER_PREFIX, PH_CMD: begin
				if (b == CH_SPACE) begin
					if (ln_phase == PH_CMD)
						ln_phase = PH_GAP;
				end else begin
					absorb_cmd_char(b);
					r.cls = CLS_CMD;
				end
			end
			PH_GAP: begin
				if (b == CH_COLON) begin
					ln_phase = PH_TRAIL;
				end else if (b != CH_SPACE) begin
					if (ln_params < MAX_PARAMS) begin
						r.idx = ln_params;
						ln_params++;
						ln_phase = PH_PARAM;
						r.cls = CLS_PARAM;
					end else begin
						ln_phase = PH_DROP;
						r.cls = CLS_DROP;
					end
				end
			end
			PH_PARAM: begin
				if (b == CH_SPACE) begin
					ln_phase = PH_GAP;
				end else begin
					r.cls = CLS_PARAM;
					r.idx = ln_params - 4'd1;
				end
			end
			PH_DROP: begin
				if (b == CH_SPACE) ln_phase = PH_GAP;
				else r.cls = CLS_DROP;
			end
			PH_TRAIL: r.cls = CLS_TRAIL;
			default: begin
				if (b == CH_AT) ln_phase = PH_TAGS;
				else if (b == CH_COLON) ln_phase = PH_NICK;
				else if (b == CH_SPACE) ln_phase = PH_GAP;
				else begin
					absorb_cmd_char(b);
					r.cls = CLS_CMD;
				end
			end
		endcase
		return r;
	endfunction

	function automatic tok_result_t byte_res(byte_class_t cls, logic [3:0] idx, logic [7:0] b);
		tok_result_t r;
		r = '0;
		r.cls = cls;
		r.idx = idx;
		r.byte_out = b;
		return r;
	endfunction

	function automatic tok_result_t eol_res(logic ok, logic numv, logic [9:0] num,
			logic [3:0] cnt);
		tok_result_t r;
		r = '0;
		r.done = 1'b1;
		r.ok = ok;
		r.numv = numv;
		r.num = num;
		r.cnt = cnt;
		return r;
	endfunction

	function automatic void add_row(logic kind, logic [7:0] data, bit typed = 1'b0,
			tok_result_t want = '0);
		stim_row_t r;
		r.kind = kind;
		r.data = data;
		r.typed = typed;
		r.want = want;
		stim.push_back(r);
	endfunction

	function automatic logic [7:0] word_char();
		logic [7:0] b;
		if ($urandom_range(3) == 0) begin
			b = 8'($urandom_range(1, 255));
			if (b == CH_SPACE)
				b = 8'h80;
		end else begin
			b = 8'($urandom_range(8'h21, 8'h7E));
		end
		return b;
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(7))
			0: return CH_AT;
			1: return CH_COLON;
			2: return CH_BANG;
			3, 4: return CH_SPACE;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic add_random_line();
		logic [7:0] ln[$];
		int mode;
		int n_par;
		int cut;
		mode = $urandom_range(99);
		if (mode < 12) begin
			repeat ($urandom_range(0, 10)) ln.push_back(noise_char());
		end else begin
			if ($urandom_range(3) == 0) begin
				ln.push_back(CH_AT);
				repeat ($urandom_range(0, 5)) ln.push_back(word_char());
				ln.push_back(CH_SPACE);
				if ($urandom_range(3) == 0) ln.push_back(CH_SPACE);
			end
			if ($urandom_range(2) == 0) begin
				ln.push_back(CH_COLON);
				repeat ($urandom_range(0, 4)) ln.push_back(word_char());
				repeat ($urandom_range(0, 2)) begin
					ln.push_back(CH_BANG);
					repeat ($urandom_range(0, 3)) ln.push_back(word_char());
				end
				ln.push_back(CH_SPACE);
			end
			if ($urandom_range(19) == 0) begin
				// empty command
				ln.push_back(CH_SPACE);
			end else begin
				case ($urandom_range(3))
					0, 1: repeat (3) ln.push_back(8'(CH_ZERO + $urandom_range(9)));
					2: repeat ($urandom_range(1, 9))
						ln.push_back($urandom_range(1) ? 8'(CH_ZERO + $urandom_range(9))
							: word_char());
					default: repeat ($urandom_range(1, 9)) ln.push_back(word_char());
				endcase
			end
			n_par = ($urandom_range(4) == 0) ? $urandom_range(13, 19) : $urandom_range(0, 4);
			repeat (n_par) begin
				ln.push_back(CH_SPACE);
				if ($urandom_range(5) == 0) ln.push_back(CH_SPACE);
				repeat ($urandom_range(1, 3)) ln.push_back(word_char());
			end
			if ($urandom_range(1)) begin
				ln.push_back(CH_SPACE);
				ln.push_back(CH_COLON);
				repeat ($urandom_range(0, 8)) ln.push_back(8'($urandom_range(1, 255)));
			end
			// break the line off early
			if (mode < 24) begin
				cut = $urandom_range(0, ln.size());
				while (ln.size() > cut) ln.delete(ln.size() - 1);
			end
		end
		foreach (ln[i]) add_row(KIND_DATA, ln[i]);
		add_row(KIND_EOL, 8'($urandom_range(0, 255)));
	endtask

	function automatic bit idle_draw();
		if (send_idx >= CALM_FROM && send_idx < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < 7;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// sender: predict each item as it is taken
	always @(posedge clk or negedge arst_n) begin : feed
		int nxt;
		tok_result_t pred;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			nxt = send_idx;
			if (s_axis_tvalid && s_axis_tready) begin
				pred = tokenize_item(s_axis_tuser, s_axis_tdata);
				expected_tokens.push_back(stim[send_idx].typed ? stim[send_idx].want : pred);
				nxt = send_idx + 1;
				send_idx <= nxt;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the item on offer
			end else if (nxt < stim.size() && !idle_draw()) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= stim[nxt].data;
				s_axis_tuser <= stim[nxt].kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !rx_hold && !idle_draw();
	end

	// long receiver stall while the sender keeps offering
	initial begin
		while (send_idx < HOLD_AT_ITEM) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin : scoreboard
		tok_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tokens.size() == 0) begin
				$error("result item with nothing pending: tdata %h tuser %0d tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("byte_class", 32'(want.cls), 32'(m_axis_tuser));
				check_field("line_done", 32'(want.done), 32'(m_axis_tlast));
				check_field("param_index", 32'(want.idx),
					32'(m_axis_tdata[OD_IDX_LSB +: 4]));
				check_field("byte_out", 32'(want.byte_out),
					32'(m_axis_tdata[OD_BYTE_LSB +: 8]));
				check_field("line_ok", 32'(want.ok), 32'(m_axis_tdata[OD_OK]));
				check_field("numeric_valid", 32'(want.numv), 32'(m_axis_tdata[OD_NUMV]));
				check_field("numeric_value", 32'(want.num),
					32'(m_axis_tdata[OD_NUM_LSB +: 10]));
				check_field("param_count", 32'(want.cnt),
					32'(m_axis_tdata[OD_CNT_LSB +: 4]));
				check_field("tdata_pad", 32'd0,
					32'(m_axis_tdata[TDATA_OUT_W-1:OD_CNT_LSB+4]));
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		// empty line straight after reset
		add_row(KIND_EOL, 8'h00, 1'b1, eol_res(1'b0, 1'b0, 10'd0, 4'd0));
		// line ending inside the tag block
		add_row(KIND_DATA, CH_AT, 1'b1, byte_res(CLS_SEP, 4'd0, CH_AT));
		add_row(KIND_DATA, "a", 1'b1, byte_res(CLS_TAG, 4'd0, "a"));
		add_row(KIND_EOL, 8'hA5, 1'b1, eol_res(1'b0, 1'b0, 10'd0, 4'd0));
		// prefix with a second bang, top numeric, one param, trailing
		add_row(KIND_DATA, CH_COLON, 1'b1, byte_res(CLS_SEP, 4'd0, CH_COLON));
		add_row(KIND_DATA, "n");
		add_row(KIND_DATA, CH_BANG, 1'b1, byte_res(CLS_SEP, 4'd0, CH_BANG));
		add_row(KIND_DATA, "h");
		add_row(KIND_DATA, CH_BANG, 1'b1, byte_res(CLS_HOST, 4'd0, CH_BANG));
		add_row(KIND_DATA, CH_SPACE);
		add_row(KIND_DATA, "9");
		add_row(KIND_DATA, "9");
		add_row(KIND_DATA, "9");
		add_row(KIND_DATA, CH_SPACE);
		add_row(KIND_DATA, "p", 1'b1, byte_res(CLS_PARAM, 4'd0, "p"));
		add_row(KIND_DATA, CH_SPACE);
		add_row(KIND_DATA, CH_COLON);
		add_row(KIND_DATA, 8'hFF, 1'b1, byte_res(CLS_TRAIL, 4'd0, 8'hFF));
		add_row(KIND_EOL, 8'hFF, 1'b1, eol_res(1'b1, 1'b1, 10'd999, 4'd1));
		// leading space leaves the command empty
		add_row(KIND_DATA, CH_SPACE, 1'b1, byte_res(CLS_SEP, 4'd0, CH_SPACE));
		add_row(KIND_DATA, "x", 1'b1, byte_res(CLS_PARAM, 4'd0, "x"));
		add_row(KIND_EOL, 8'h00, 1'b1, eol_res(1'b1, 1'b0, 10'd0, 4'd1));
		// extreme byte values as command
		add_row(KIND_DATA, 8'h01, 1'b1, byte_res(CLS_CMD, 4'd0, 8'h01));
		add_row(KIND_DATA, 8'hFF, 1'b1, byte_res(CLS_CMD, 4'd0, 8'hFF));
		add_row(KIND_EOL, 8'h5A, 1'b1, eol_res(1'b1, 1'b0, 10'd0, 4'd0));
		while (stim.size() < 25 + RANDOM_ITEMS) add_random_line();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (send_idx < stim.size() || expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
design/ilt_pkg.sv
design/irc_line_tokenizer.sv
design/ilt_checker.sv
sim/tb_top.sv
